>>> rtl/tdsm_pkg.sv
// ----------------------------------------------------------------------------
// tdsm_pkg
// Shared constants, record layouts and codes of the event state machine.
// ----------------------------------------------------------------------------
package tdsm_pkg;

  localparam int unsigned TRANS_ENTRIES = 16;
  localparam int unsigned COND_ENTRIES  = 16;

  localparam int unsigned TRANS_AW = (TRANS_ENTRIES > 1) ? $clog2(TRANS_ENTRIES) : 1;
  localparam int unsigned COND_AW  = (COND_ENTRIES > 1) ? $clog2(COND_ENTRIES) : 1;
  localparam int unsigned TRANS_CW = $clog2(TRANS_ENTRIES + 1);

  typedef enum logic [1:0] {
    OP_EVENT    = 2'd0,
    OP_OUTCOME  = 2'd1,
    OP_WR_TRANS = 2'd2,
    OP_WR_COND  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_NONE    = 3'd0,
    KIND_RUN     = 3'd1,
    KIND_NEW     = 3'd2,
    KIND_WRITTEN = 3'd3,
    KIND_BUSY    = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    CMP_EQ = 3'd0,
    CMP_LE = 3'd1,
    CMP_GE = 3'd2,
    CMP_LT = 3'd3,
    CMP_GT = 3'd4
  } cmp_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUTCOME,
    ST_DONE
  } fsm_e;

  typedef struct packed {
    logic [7:0] from_state;
    logic [3:0] cond_sel;
    logic [7:0] action;
    logic [7:0] to_ok;
    logic [7:0] to_fail;
  } trans_rec_t;

  typedef struct packed {
    logic [7:0] ip;
    logic [7:0] eid;
    logic [7:0] value;
    logic [2:0] compare_op;
  } cond_rec_t;

  typedef struct packed {
    logic [7:0] ip;
    logic [7:0] eid;
    logic [7:0] value;
  } evt_key_t;

  localparam int unsigned TRANS_W = $bits(trans_rec_t);
  localparam int unsigned COND_W  = $bits(cond_rec_t);

endpackage

>>> rtl/tdsm_in_if.sv
// ----------------------------------------------------------------------------
// tdsm_in_if
// Input channel: events, action outcomes and table writes.
// ----------------------------------------------------------------------------
interface tdsm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] ip;
  logic [7:0] eid;
  logic [7:0] value;
  logic       action_failed;
  logic [3:0] entry_index;
  logic [7:0] from_state;
  logic [3:0] cond_sel;
  logic [7:0] action;
  logic [7:0] to_ok;
  logic [7:0] to_fail;
  logic [2:0] compare_op;

  modport source (
    output valid, op, ip, eid, value, action_failed, entry_index,
           from_state, cond_sel, action, to_ok, to_fail, compare_op,
    input  ready
  );

  modport sink (
    input  valid, op, ip, eid, value, action_failed, entry_index,
           from_state, cond_sel, action, to_ok, to_fail, compare_op,
    output ready
  );
endinterface

>>> rtl/tdsm_out_if.sv
// ----------------------------------------------------------------------------
// tdsm_out_if
// Result channel: one result per input transaction.
// ----------------------------------------------------------------------------
interface tdsm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] result_kind;
  logic [7:0] action_number;
  logic [7:0] current_state;
  logic [3:0] matched_entry;

  modport source (
    output valid, result_kind, action_number, current_state, matched_entry,
    input  ready
  );

  modport sink (
    input  valid, result_kind, action_number, current_state, matched_entry,
    output ready
  );
endinterface

>>> rtl/tdsm_ram.sv
// ----------------------------------------------------------------------------
// tdsm_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tdsm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tdsm_match.sv
// ----------------------------------------------------------------------------
// tdsm_match
// Condition test: address and endpoint equality, then value compare with the
// stored value on the left.
// ----------------------------------------------------------------------------
module tdsm_match (
  input  tdsm_pkg::cond_rec_t cond_i,
  input  logic                cond_ok_i,
  input  tdsm_pkg::evt_key_t  key_i,
  output logic                hit_o
);
  import tdsm_pkg::*;

  logic cmp_hit;

  always_comb begin
    unique case (cmp_e'(cond_i.compare_op))
      CMP_EQ:  cmp_hit = (cond_i.value == key_i.value);
      CMP_LE:  cmp_hit = (cond_i.value <= key_i.value);
      CMP_GE:  cmp_hit = (cond_i.value >= key_i.value);
      CMP_LT:  cmp_hit = (cond_i.value <  key_i.value);
      CMP_GT:  cmp_hit = (cond_i.value >  key_i.value);
      default: cmp_hit = 1'b0;
    endcase
  end

  assign hit_o = cond_ok_i && (cond_i.ip == key_i.ip) && (cond_i.eid == key_i.eid) && cmp_hit;

endmodule

>>> rtl/table_driven_event_state_machine.sv
// ----------------------------------------------------------------------------
// table_driven_event_state_machine
// Event/condition/action state machine over a transition RAM and a
// condition RAM, scanned by a three-stage read pipeline.
//
//   channel  dir  handshake      payload
//   evt_i    in   valid/ready    op, ip, eid, value, action_failed, entry_index,
//                                from_state, cond_sel, action, to_ok,
//                                to_fail, compare_op
//   res_o    out  valid/ready    result_kind, action_number, current_state,
//                                matched_entry
//
// Writes and busy results go straight to the result; an outcome first needs
// one RAM read. An event scan issues one transition read per cycle, then the
// dependent condition read, then compare, and it stops at the first hit.
// One transaction is in work at a time; the result register frees the input
// side while a result waits. Reset clears state, pending flag and valid bits.
// ----------------------------------------------------------------------------
module table_driven_event_state_machine (
  input  logic      clk_i,
  input  logic      rst_ni,
  tdsm_in_if.sink   evt_i,
  tdsm_out_if.source res_o
);
  import tdsm_pkg::*;

  fsm_e                st_q, st_d;
  logic [TRANS_CW-1:0] issue_q, issue_d;
  logic                issue_en;
  logic                s1_vld_q, s2_vld_q, s2_vld_d;
  logic [TRANS_AW-1:0] s1_idx_q, s2_idx_q;
  logic                s2_pre_q, s1_pre;
  trans_rec_t          s2_trans_q;
  evt_key_t            key_q;
  logic                failed_q;

  logic [7:0]          state_now_q, state_now_d;
  logic                pending_q, pending_d;
  logic [3:0]          pending_entry_q, pending_entry_d;
  logic [TRANS_ENTRIES-1:0] trans_valid_q;
  logic [COND_ENTRIES-1:0]  cond_valid_q;

  kind_e               res_kind_q, res_kind_d;
  logic [7:0]          res_act_q, res_act_d;
  logic [3:0]          res_match_q, res_match_d;

  logic                out_vld_q, out_load;
  kind_e               out_kind_q;
  logic [7:0]          out_act_q, out_state_q;
  logic [3:0]          out_match_q;

  logic                accept;
  logic                trans_we, cond_we;
  logic [TRANS_AW-1:0] trans_waddr, trans_raddr;
  logic [COND_AW-1:0]  cond_waddr, cond_raddr;
  trans_rec_t          trans_wdata, trans_rdata;
  cond_rec_t           cond_wdata, cond_rdata;
  logic                cond_hit, hit, scan_end;

  assign accept = evt_i.valid && evt_i.ready;
  assign evt_i.ready = (st_q == ST_IDLE);

  assign trans_waddr = TRANS_AW'(evt_i.entry_index);
  assign cond_waddr  = COND_AW'(evt_i.entry_index);
  assign trans_wdata = '{from_state: evt_i.from_state, cond_sel: evt_i.cond_sel,
                         action: evt_i.action, to_ok: evt_i.to_ok, to_fail: evt_i.to_fail};
  assign cond_wdata  = '{ip: evt_i.ip, eid: evt_i.eid, value: evt_i.value,
                         compare_op: evt_i.compare_op};
  assign cond_raddr  = COND_AW'(trans_rdata.cond_sel);

  tdsm_ram #(.Width(TRANS_W), .Depth(TRANS_ENTRIES)) u_trans_ram (
    .clk_i   (clk_i),
    .we_i    (trans_we),
    .waddr_i (trans_waddr),
    .wdata_i (trans_wdata),
    .raddr_i (trans_raddr),
    .rdata_o (trans_rdata)
  );

  tdsm_ram #(.Width(COND_W), .Depth(COND_ENTRIES)) u_cond_ram (
    .clk_i   (clk_i),
    .we_i    (cond_we),
    .waddr_i (cond_waddr),
    .wdata_i (cond_wdata),
    .raddr_i (cond_raddr),
    .rdata_o (cond_rdata)
  );

  tdsm_match u_match (
    .cond_i    (cond_rdata),
    .cond_ok_i (s2_pre_q),
    .key_i     (key_q),
    .hit_o     (cond_hit)
  );

  assign s1_pre = trans_valid_q[s1_idx_q] &&
                  (trans_rdata.from_state == state_now_q) &&
                  (32'(trans_rdata.cond_sel) < COND_ENTRIES) &&
                  cond_valid_q[COND_AW'(trans_rdata.cond_sel)];

  assign hit      = (st_q == ST_SCAN) && s2_vld_q && cond_hit;
  assign scan_end = hit || ((st_q == ST_SCAN) && s2_vld_q &&
                            (s2_idx_q == TRANS_AW'(TRANS_ENTRIES - 1)));
  assign s2_vld_d = s1_vld_q && (st_q == ST_SCAN);

  always_comb begin
    st_d            = st_q;
    issue_d         = issue_q;
    issue_en        = 1'b0;
    state_now_d     = state_now_q;
    pending_d       = pending_q;
    pending_entry_d = pending_entry_q;
    res_kind_d      = res_kind_q;
    res_act_d       = res_act_q;
    res_match_d     = res_match_q;
    trans_we        = 1'b0;
    cond_we         = 1'b0;
    out_load        = 1'b0;
    trans_raddr     = issue_q[TRANS_AW-1:0];

    unique case (st_q)
      ST_IDLE: begin
        trans_raddr = TRANS_AW'(pending_entry_q);
        if (accept) begin
          res_act_d   = '0;
          res_match_d = '0;
          st_d        = ST_DONE;
          unique case (op_e'(evt_i.op))
            OP_EVENT: begin
              if (pending_q) begin
                res_kind_d  = KIND_BUSY;
                res_match_d = pending_entry_q;
              end else begin
                issue_d = '0;
                st_d    = ST_SCAN;
              end
            end
            OP_OUTCOME: begin
              if (pending_q) begin
                st_d = ST_OUTCOME;
              end else begin
                res_kind_d = KIND_BUSY;
              end
            end
            OP_WR_TRANS: begin
              trans_we   = (32'(evt_i.entry_index) < TRANS_ENTRIES);
              res_kind_d = KIND_WRITTEN;
            end
            OP_WR_COND: begin
              cond_we    = (32'(evt_i.entry_index) < COND_ENTRIES);
              res_kind_d = KIND_WRITTEN;
            end
            default: st_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        issue_en = (32'(issue_q) < TRANS_ENTRIES);
        if (issue_en) begin
          issue_d = issue_q + 1'b1;
        end
        if (scan_end) begin
          st_d = ST_DONE;
          if (hit) begin
            res_kind_d      = KIND_RUN;
            res_act_d       = s2_trans_q.action;
            res_match_d     = 4'(s2_idx_q);
            pending_d       = 1'b1;
            pending_entry_d = 4'(s2_idx_q);
          end else begin
            res_kind_d = KIND_NONE;
          end
        end
      end
      ST_OUTCOME: begin
        state_now_d = failed_q ? trans_rdata.to_fail : trans_rdata.to_ok;
        pending_d   = 1'b0;
        res_kind_d  = KIND_NEW;
        res_match_d = pending_entry_q;
        st_d        = ST_DONE;
      end
      ST_DONE: begin
        if (!out_vld_q || res_o.ready) begin
          out_load = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q            <= ST_IDLE;
      issue_q         <= '0;
      s1_vld_q        <= 1'b0;
      s2_vld_q        <= 1'b0;
      state_now_q     <= '0;
      pending_q       <= 1'b0;
      pending_entry_q <= '0;
      trans_valid_q   <= '0;
      cond_valid_q    <= '0;
      out_vld_q       <= 1'b0;
    end else begin
      st_q            <= st_d;
      issue_q         <= issue_d;
      s1_vld_q        <= issue_en;
      s2_vld_q        <= s2_vld_d;
      state_now_q     <= state_now_d;
      pending_q       <= pending_d;
      pending_entry_q <= pending_entry_d;
      if (trans_we) begin
        trans_valid_q[trans_waddr] <= 1'b1;
      end
      if (cond_we) begin
        cond_valid_q[cond_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q    <= issue_q[TRANS_AW-1:0];
    s2_idx_q    <= s1_idx_q;
    s2_pre_q    <= s1_pre;
    s2_trans_q  <= trans_rdata;
    res_kind_q  <= res_kind_d;
    res_act_q   <= res_act_d;
    res_match_q <= res_match_d;
    if (accept) begin
      key_q    <= '{ip: evt_i.ip, eid: evt_i.eid, value: evt_i.value};
      failed_q <= evt_i.action_failed;
    end
    if (out_load) begin
      out_kind_q  <= res_kind_q;
      out_act_q   <= res_act_q;
      out_state_q <= state_now_q;
      out_match_q <= res_match_q;
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.result_kind   = out_kind_q;
  assign res_o.action_number = out_act_q;
  assign res_o.current_state = out_state_q;
  assign res_o.matched_entry = out_match_q;

  a_scan_not_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_SCAN) |-> !pending_q)
    else $error("scan running while an action is pending");

  a_outcome_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_OUTCOME) |-> pending_q)
    else $error("outcome applied with no action pending");

  a_pending_on_run : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pending_q) |-> (st_q == ST_DONE) && (res_kind_q == KIND_RUN))
    else $error("pending flag set without a run result");

  a_load_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (st_q == ST_DONE) && (!out_vld_q || res_o.ready))
    else $error("result register overwritten while occupied");

endmodule

>>> tb/tdsm_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tdsm_result_checker
// Watches both channels of the event state machine. Every accepted input
// transaction is run through a local model of the current state, the
// transition and condition tables and the pending action. The result it
// predicts is queued. Each accepted result is compared field by field with
// the oldest queued prediction. Mismatch and pending counts go to the top.
// ----------------------------------------------------------------------------
module tdsm_result_checker (
  input  logic clk_i,
  input  logic rst_ni,
  tdsm_in_if   evt,
  tdsm_out_if  res,
  output int   err_cnt_o,
  output int   pend_cnt_o
);
  import tdsm_pkg::*;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] action;
    logic [7:0] state;
    logic [3:0] entry;
  } res_t;

  logic [7:0] state_q;
  trans_rec_t trans_tab [TRANS_ENTRIES];
  logic       trans_ok  [TRANS_ENTRIES];
  cond_rec_t  cond_tab  [COND_ENTRIES];
  logic       cond_ok   [COND_ENTRIES];
  logic       busy_q;
  logic [3:0] busy_idx;
  res_t       due_q [$];
  int         errors;

  function automatic logic cond_hit(input logic [3:0] ci, input logic [7:0] ip,
                                    input logic [7:0] eid, input logic [7:0] v);
    cond_rec_t c;
    if (ci >= COND_ENTRIES || !cond_ok[ci]) return 1'b0;
    c = cond_tab[ci];
    if (c.ip != ip || c.eid != eid) return 1'b0;
    case (c.compare_op)
      CMP_EQ:  return c.value == v;
      CMP_LE:  return c.value <= v;
      CMP_GE:  return c.value >= v;
      CMP_LT:  return c.value < v;
      CMP_GT:  return c.value > v;
      default: return 1'b0;
    endcase
  endfunction

  function automatic res_t step_machine(input op_e op, input logic [7:0] ip,
                                        input logic [7:0] eid, input logic [7:0] value,
                                        input logic failed, input logic [3:0] idx,
                                        input trans_rec_t tr, input cond_rec_t cr);
    res_t r;
    r = '0;
    r.kind = KIND_NONE;
    case (op)
      OP_EVENT: begin
        if (busy_q) begin
          r.kind  = KIND_BUSY;
          r.entry = busy_idx;
        end else begin
          for (int i = 0; i < TRANS_ENTRIES; i++) begin
            if (trans_ok[i] && trans_tab[i].from_state == state_q &&
                cond_hit(trans_tab[i].cond_sel, ip, eid, value)) begin
              r.kind   = KIND_RUN;
              r.action = trans_tab[i].action;
              r.entry  = 4'(i);
              busy_q   = 1'b1;
              busy_idx = 4'(i);
              break;
            end
          end
        end
      end
      OP_OUTCOME: begin
        if (!busy_q) begin
          r.kind = KIND_BUSY;
        end else begin
          state_q = failed ? trans_tab[busy_idx].to_fail : trans_tab[busy_idx].to_ok;
          busy_q  = 1'b0;
          r.kind  = KIND_NEW;
          r.entry = busy_idx;
        end
      end
      OP_WR_TRANS: begin
        if (idx < TRANS_ENTRIES) begin
          trans_tab[idx] = tr;
          trans_ok[idx]  = 1'b1;
        end
        r.kind = KIND_WRITTEN;
      end
      default: begin
        if (idx < COND_ENTRIES) begin
          cond_tab[idx] = cr;
          cond_ok[idx]  = 1'b1;
        end
        r.kind = KIND_WRITTEN;
      end
    endcase
    r.state = state_q;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      state_q  = '0;
      busy_q   = 1'b0;
      busy_idx = '0;
      for (int i = 0; i < TRANS_ENTRIES; i++) trans_ok[i] = 1'b0;
      for (int i = 0; i < COND_ENTRIES; i++) cond_ok[i] = 1'b0;
      due_q.delete();
      errors = 0;
      err_cnt_o  <= 0;
      pend_cnt_o <= 0;
    end else begin
      if (evt.valid === 1'b1 && evt.ready === 1'b1) begin
        due_q.push_back(step_machine(
          op_e'(evt.op), evt.ip, evt.eid, evt.value, evt.action_failed, evt.entry_index,
          trans_rec_t'{evt.from_state, evt.cond_sel, evt.action, evt.to_ok, evt.to_fail},
          cond_rec_t'{evt.ip, evt.eid, evt.value, evt.compare_op}));
      end
      if (res.valid === 1'b1 && res.ready === 1'b1) begin
        if (due_q.size() == 0) begin
          $display("%0t: result transaction with nothing expected, %s %0d",
                   $time, "expected none, actual kind", res.result_kind);
          errors++;
        end else begin
          want = due_q.pop_front();
          check_field("result_kind", 32'(want.kind), 32'(res.result_kind));
          check_field("action_number", 32'(want.action), 32'(res.action_number));
          check_field("current_state", 32'(want.state), 32'(res.current_state));
          check_field("matched_entry", 32'(want.entry), 32'(res.matched_entry));
        end
      end
      err_cnt_o  <= errors;
      pend_cnt_o <= due_q.size();
    end
  end

endmodule

>>> tb/tb_table_driven_event_state_machine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_table_driven_event_state_machine
// Stimulus for the event state machine: a directed sequence through the
// table writes, busy cases, every compare code and both outcomes, then
// random transactions shaped so events often find a matching transition and
// are followed by outcomes. Both channels idle at random, with one stretch
// at full rate. The result checker predicts and compares; this top only
// drives and reports the verdict.
// ----------------------------------------------------------------------------
module tb_table_driven_event_state_machine;
  import tdsm_pkg::*;

  localparam int CLK_PERIOD = 4;
  localparam int RAND_ITEMS = 450;
  localparam logic [2:0] CMP_NEVER = 3'd7;

  typedef struct {
    op_e        op;
    logic [7:0] ip;
    logic [7:0] eid;
    logic [7:0] value;
    logic       failed;
    logic [3:0] entry_index;
    logic [7:0] from_state;
    logic [3:0] cond_sel;
    logic [7:0] action;
    logic [7:0] to_ok;
    logic [7:0] to_fail;
    logic [2:0] compare_op;
  } cmd_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic quiet;
  int   err_cnt;
  int   pend_cnt;

  tdsm_in_if  evt ();
  tdsm_out_if res ();

  table_driven_event_state_machine dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt),
    .res_o  (res)
  );

  tdsm_result_checker u_result_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt        (evt),
    .res        (res),
    .err_cnt_o  (err_cnt),
    .pend_cnt_o (pend_cnt)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic cmd_t blank(input op_e op);
    cmd_t c;
    c = '{op: op, default: '0};
    return c;
  endfunction

  function automatic cmd_t mk_event(input logic [7:0] ip, input logic [7:0] eid,
                                    input logic [7:0] v);
    cmd_t c;
    c = blank(OP_EVENT);
    c.ip = ip;
    c.eid = eid;
    c.value = v;
    return c;
  endfunction

  function automatic cmd_t mk_outcome(input logic failed);
    cmd_t c;
    c = blank(OP_OUTCOME);
    c.failed = failed;
    return c;
  endfunction

  function automatic cmd_t mk_trans(input logic [3:0] idx, input logic [7:0] from,
                                    input logic [3:0] ci, input logic [7:0] act,
                                    input logic [7:0] ok, input logic [7:0] fail);
    cmd_t c;
    c = blank(OP_WR_TRANS);
    c.entry_index = idx;
    c.from_state = from;
    c.cond_sel = ci;
    c.action = act;
    c.to_ok = ok;
    c.to_fail = fail;
    return c;
  endfunction

  function automatic cmd_t mk_cond(input logic [3:0] idx, input logic [7:0] ip,
                                   input logic [7:0] eid, input logic [7:0] v,
                                   input logic [2:0] cmp);
    cmd_t c;
    c = blank(OP_WR_COND);
    c.entry_index = idx;
    c.ip = ip;
    c.eid = eid;
    c.value = v;
    c.compare_op = cmp;
    return c;
  endfunction

  function automatic logic [7:0] pick_near(input int unsigned top_v);
    return ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(top_v));
  endfunction

  task automatic send(input cmd_t c);
    while (!quiet && $urandom_range(99) < 6) begin
      evt.valid <= 1'b0;
      @(negedge clk_i);
    end
    evt.valid         <= 1'b1;
    evt.op            <= c.op;
    evt.ip            <= c.ip;
    evt.eid           <= c.eid;
    evt.value         <= c.value;
    evt.action_failed <= c.failed;
    evt.entry_index   <= c.entry_index;
    evt.from_state    <= c.from_state;
    evt.cond_sel      <= c.cond_sel;
    evt.action        <= c.action;
    evt.to_ok         <= c.to_ok;
    evt.to_fail       <= c.to_fail;
    evt.compare_op    <= c.compare_op;
    @(posedge clk_i);
    while (evt.ready !== 1'b1) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 6);
    end
  end

  initial begin
    #(CLK_PERIOD * 400000);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    cmd_t c;
    int   pick;
    quiet = 1'b0;
    rst_ni = 1'b0;
    evt.valid = 1'b0;
    evt.op = OP_EVENT;
    evt.ip = '0;
    evt.eid = '0;
    evt.value = '0;
    evt.action_failed = 1'b0;
    evt.entry_index = '0;
    evt.from_state = '0;
    evt.cond_sel = '0;
    evt.action = '0;
    evt.to_ok = '0;
    evt.to_fail = '0;
    evt.compare_op = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send(mk_event(8'd0, 8'd0, 8'd0));
    send(mk_outcome(1'b0));
    send(mk_cond(4'd0, 8'd255, 8'd255, 8'd255, CMP_EQ));
    send(mk_cond(4'd15, 8'd0, 8'd0, 8'd0, CMP_GE));
    send(mk_cond(4'd1, 8'd1, 8'd2, 8'd100, CMP_LT));
    send(mk_cond(4'd2, 8'd1, 8'd2, 8'd100, CMP_GT));
    send(mk_cond(4'd3, 8'd1, 8'd2, 8'd100, CMP_NEVER));
    send(mk_cond(4'd4, 8'd1, 8'd2, 8'd100, CMP_LE));
    send(mk_trans(4'd0, 8'd0, 4'd5, 8'd7, 8'd1, 8'd1));
    send(mk_trans(4'd15, 8'd0, 4'd3, 8'd9, 8'd2, 8'd2));
    send(mk_trans(4'd1, 8'd0, 4'd1, 8'hAA, 8'd255, 8'h10));
    send(mk_event(8'd1, 8'd2, 8'd100));
    send(mk_event(8'd1, 8'd2, 8'd101));
    send(mk_event(8'd1, 8'd2, 8'd101));
    send(mk_trans(4'd1, 8'd0, 4'd1, 8'hAA, 8'h80, 8'h10));
    send(mk_outcome(1'b0));
    send(mk_trans(4'd2, 8'h80, 4'd0, 8'hFF, 8'd0, 8'hFF));
    send(mk_event(8'd255, 8'd255, 8'd255));
    send(mk_outcome(1'b1));
    send(mk_trans(4'd14, 8'hFF, 4'd15, 8'd0, 8'd0, 8'd0));
    send(mk_event(8'd0, 8'd0, 8'd1));
    send(mk_event(8'd0, 8'd0, 8'd0));
    send(mk_outcome(1'b0));

    evt.valid <= 1'b0;
    while (pend_cnt != 0) @(negedge clk_i);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      quiet = (n >= RAND_ITEMS / 3 && n < 2 * RAND_ITEMS / 3);
      c.op          = op_e'($urandom_range(3));
      c.ip          = 8'($urandom);
      c.eid         = 8'($urandom);
      c.value       = 8'($urandom);
      c.failed      = 1'($urandom);
      c.entry_index = 4'($urandom);
      c.from_state  = 8'($urandom);
      c.cond_sel    = 4'($urandom);
      c.action      = 8'($urandom);
      c.to_ok       = 8'($urandom);
      c.to_fail     = 8'($urandom);
      c.compare_op  = 3'($urandom);
      pick = $urandom_range(99);
      if (pick < 40) begin
        c.op  = OP_EVENT;
        c.ip  = pick_near(1);
        c.eid = pick_near(1);
      end else if (pick < 70) begin
        c.op = OP_OUTCOME;
      end else if (pick < 85) begin
        c.op         = OP_WR_TRANS;
        c.from_state = pick_near(3);
        c.to_ok      = pick_near(3);
        c.to_fail    = pick_near(3);
      end else if (pick < 97) begin
        c.op  = OP_WR_COND;
        c.ip  = pick_near(1);
        c.eid = pick_near(1);
        if ($urandom_range(3) != 0) c.compare_op = 3'($urandom_range(4));
      end
      send(c);
    end
    evt.valid <= 1'b0;
    quiet = 1'b0;

    while (pend_cnt != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
